@@ rtl/lwb_pkg.sv @@
`default_nettype none

package lwb_pkg;

    // window defaults after reset
    localparam int unsigned DEF_SCREEN_WIDTH  = 192;
    localparam int unsigned DEF_SCREEN_HEIGHT = 64;
    localparam logic [7:0]  RST_WIN_WIDTH     = 8'd192;
    localparam logic [7:0]  RST_WIN_HEIGHT    = 8'd64;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 2'd3;

    // display command bytes
    localparam logic [7:0] CMD_COL_LSB = 8'h00;
    localparam logic [7:0] CMD_COL_MSB = 8'h10;
    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] NIB_LO_MASK = 8'h0F;
    localparam logic [7:0] NIB_HI_MASK = 8'hF0;

    // result slot positions inside one bundle
    localparam logic [1:0] SLOT_COL_LSB = 2'd0;
    localparam logic [1:0] SLOT_COL_MSB = 2'd1;
    localparam logic [1:0] SLOT_PAGE    = 2'd2;
    localparam logic [1:0] SLOT_DATA    = 2'd3;

    // everything one input item produces
    typedef struct packed {
        logic       cmd;     // three address commands lead
        logic       data;    // pixel byte is forwarded
        logic       last;    // final byte of the window
        logic [7:0] column;
        logic [7:0] page;
        logic [7:0] pixel;
    } lwb_bundle_t;

    // emitter status back to the tracker
    typedef struct packed {
        logic       pop;     // bundle fully handed to the output register
        logic [1:0] idx;     // slot being emitted next
    } lwb_emit_stat_t;

endpackage

`default_nettype wire

@@ rtl/lcd_window_blit_sequencer.sv @@
// Window blit sequencer for a page-addressed monochrome LCD.
// Input channel (in_valid/in_ready, pixel_byte): bitmap bytes of the window
// in page-row order, win_width bytes per page row. Output channel
// (out_valid/out_ready, out_byte, is_command, window_done): bytes for the
// display link; each visible page row opens with three address commands.
// Configuration: cfg_wr_en with cfg_index 0..3 selects win_x, win_y,
// win_width, win_height; any write restarts the window. Write only while idle.
// An accepted item is registered in the bundle register, then in the output register.
// Throughput: one item per cycle when it gives at most one result and the
// receiver does not stall; an item that opens a visible page row holds the
// input until its three address commands, and its pixel byte when that is
// on screen, are emitted by the single output register, one result per cycle.
// Items off screen, or any item of an empty window, are taken and dropped.
// Reset clears the counters, loads the default window (192 x 64 at 0,0) and
// empties both the bundle and output registers.
// While the receiver stalls the output holds; one pending bundle is kept
// and in_ready drops until that bundle drains.
`default_nettype none

module lcd_window_blit_sequencer #(
    parameter int unsigned SCREEN_WIDTH  = lwb_pkg::DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = lwb_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lwb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lwb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      pixel_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [7:0]                           out_byte,
    output logic                                 is_command,
    output logic                                 window_done
);
    import lwb_pkg::*;

    logic           bnd_valid;
    lwb_bundle_t    bnd;
    lwb_emit_stat_t stat;

    // window counters and per-item bundle
    lwb_track #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_byte (pixel_byte),
        .stat       (stat),
        .bnd_valid  (bnd_valid),
        .bnd        (bnd)
    );

    // serialize bundle into output items
    lwb_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .bnd_valid   (bnd_valid),
        .bnd         (bnd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .is_command  (is_command),
        .window_done (window_done)
    );

`ifndef ASSERT_OFF
    // a bundle only drains while one is present
    a_pop_needs_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        stat.pop |-> bnd_valid)
        else $error("bundle popped while empty");

    // slot index moves only inside a command bundle
    a_idx_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (bnd_valid && stat.idx != SLOT_COL_LSB) |-> bnd.cmd)
        else $error("slot index advanced on data-only bundle");

    // stalled output never drops a bundle
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !stat.pop)
        else $error("bundle popped during output stall");

    // input backpressure only when a bundle is pending
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> bnd_valid)
        else $error("input stalled with no pending bundle");
`endif

endmodule

`default_nettype wire

@@ rtl/lwb_track.sv @@
`default_nettype none

module lwb_track #(
    parameter int unsigned SCREEN_WIDTH  = lwb_pkg::DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT = lwb_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [lwb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lwb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [7:0]                      pixel_byte,
    input  wire lwb_pkg::lwb_emit_stat_t         stat,
    output logic                                 bnd_valid,
    output lwb_pkg::lwb_bundle_t                 bnd
);
    import lwb_pkg::*;

    logic signed [8:0] win_x_reg, win_x_next;
    logic signed [8:0] win_y_reg, win_y_next;
    logic [7:0]        win_width_reg, win_width_next;
    logic [7:0]        win_height_reg, win_height_next;
    logic [7:0]        src_col_reg, src_col_next;
    logic [8:0]        src_row_reg, src_row_next;
    logic [7:0]        page_addr_reg, page_addr_next;
    logic              bnd_valid_reg, bnd_valid_next;
    lwb_bundle_t       bnd_reg, bnd_next;

    logic [10:0] row_pos;
    logic [10:0] col_pos;
    logic        row_vis;
    logic        col_vis;
    logic        empty;
    logic        accept;
    logic [8:0]  col_inc;
    logic [9:0]  row_inc;
    logic        row_end;
    logic        win_end;
    logic [7:0]  start_page;
    logic        cmd_now;
    logic        data_now;

    // window position of the current byte
    always_comb
    begin
        row_pos = {{2{win_y_reg[8]}}, win_y_reg} + {2'b00, src_row_reg};
        col_pos = {{2{win_x_reg[8]}}, win_x_reg} + {3'b000, src_col_reg};
        row_vis = !row_pos[10] && (row_pos[9:0] < 10'(SCREEN_HEIGHT));
        col_vis = !col_pos[10] && (col_pos[9:0] < 10'(SCREEN_WIDTH));
        empty   = (win_width_reg == 8'd0) || (win_height_reg == 8'd0);
        col_inc = {1'b0, src_col_reg} + 9'd1;
        row_inc = {1'b0, src_row_reg} + 10'd8;
        row_end = col_inc >= {1'b0, win_width_reg};
        win_end = row_end && (row_inc >= {2'b00, win_height_reg});
        cmd_now  = row_vis && (src_col_reg == 8'd0);
        data_now = row_vis && col_vis;
    end

    // accept while the bundle slot is free or drains this cycle
    assign in_ready = !bnd_valid_reg || stat.pop;
    assign accept   = in_valid && in_ready;

    // configuration and window counters
    always_comb
    begin
        win_x_next      = win_x_reg;
        win_y_next      = win_y_reg;
        win_width_next  = win_width_reg;
        win_height_next = win_height_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WIN_X:      win_x_next      = cfg_data;
                REG_WIN_Y:      win_y_next      = cfg_data;
                REG_WIN_WIDTH:  win_width_next  = cfg_data[7:0];
                REG_WIN_HEIGHT: win_height_next = cfg_data[7:0];
                default:        win_x_next      = win_x_reg;
            endcase
        end
        start_page = win_y_next[8] ? 8'd0 : {3'b000, win_y_next[7:3]};

        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        page_addr_next = page_addr_reg;
        if (cfg_wr_en)
        begin
            src_col_next   = 8'd0;
            src_row_next   = 9'd0;
            page_addr_next = start_page;
        end
        else if (accept && !empty)
        begin
            if (cmd_now)
            begin
                page_addr_next = page_addr_reg + 8'd1;
            end
            if (row_end)
            begin
                src_col_next = 8'd0;
                src_row_next = row_inc[8:0];
                if (win_end)
                begin
                    src_row_next   = 9'd0;
                    page_addr_next = start_page;
                end
            end
            else
            begin
                src_col_next = col_inc[7:0];
            end
        end
    end

    // bundle register
    always_comb
    begin
        bnd_valid_next = bnd_valid_reg && !stat.pop;
        bnd_next       = bnd_reg;
        if (accept && !empty && (cmd_now || data_now))
        begin
            bnd_valid_next  = 1'b1;
            bnd_next.cmd    = cmd_now;
            bnd_next.data   = data_now;
            bnd_next.last   = win_end;
            bnd_next.column = win_x_reg[8] ? 8'd0 : win_x_reg[7:0];
            bnd_next.page   = page_addr_reg;
            bnd_next.pixel  = pixel_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg      <= '0;
            win_y_reg      <= '0;
            win_width_reg  <= RST_WIN_WIDTH;
            win_height_reg <= RST_WIN_HEIGHT;
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            page_addr_reg  <= '0;
            bnd_valid_reg  <= 1'b0;
        end
        else
        begin
            win_x_reg      <= win_x_next;
            win_y_reg      <= win_y_next;
            win_width_reg  <= win_width_next;
            win_height_reg <= win_height_next;
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            page_addr_reg  <= page_addr_next;
            bnd_valid_reg  <= bnd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bnd_reg <= bnd_next;
    end

    assign bnd_valid = bnd_valid_reg;
    assign bnd       = bnd_reg;

endmodule

`default_nettype wire

@@ rtl/lwb_emit.sv @@
`default_nettype none

module lwb_emit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     bnd_valid,
    input  wire lwb_pkg::lwb_bundle_t     bnd,
    output lwb_pkg::lwb_emit_stat_t       stat,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [7:0]                    out_byte,
    output logic                          is_command,
    output logic                          window_done
);
    import lwb_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       is_command_reg, is_command_next;
    logic       window_done_reg, window_done_next;

    logic       load;
    logic       final_slot;
    logic [1:0] slot;

    // pick the slot for the current index
    always_comb
    begin
        slot = bnd.cmd ? idx_reg : SLOT_DATA;
        case (slot)
            SLOT_COL_LSB: final_slot = 1'b0;
            SLOT_COL_MSB: final_slot = 1'b0;
            SLOT_PAGE:    final_slot = !bnd.data;
            SLOT_DATA:    final_slot = 1'b1;
            default:      final_slot = 1'b1;
        endcase
        load = bnd_valid && (!out_valid_reg || out_ready);
    end

    // output register, one result per cycle while the receiver does not stall
    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        out_byte_next    = out_byte_reg;
        is_command_next  = is_command_reg;
        window_done_next = window_done_reg;
        idx_next         = idx_reg;
        if (load)
        begin
            out_valid_next   = 1'b1;
            window_done_next = bnd.last && final_slot;
            case (slot)
                SLOT_COL_LSB:
                begin
                    out_byte_next   = CMD_COL_LSB | (bnd.column & NIB_LO_MASK);
                    is_command_next = 1'b1;
                end
                SLOT_COL_MSB:
                begin
                    out_byte_next   = CMD_COL_MSB | ((bnd.column & NIB_HI_MASK) >> 4);
                    is_command_next = 1'b1;
                end
                SLOT_PAGE:
                begin
                    out_byte_next   = CMD_PAGE | bnd.page;
                    is_command_next = 1'b1;
                end
                default:
                begin
                    out_byte_next   = bnd.pixel;
                    is_command_next = 1'b0;
                end
            endcase
            idx_next = final_slot ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        is_command_reg  <= is_command_next;
        window_done_reg <= window_done_next;
    end

    assign stat.pop    = load && final_slot;
    assign stat.idx    = idx_reg;
    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign is_command  = is_command_reg;
    assign window_done = window_done_reg;

endmodule

`default_nettype wire
